### hdl/adc2p_pkg.sv
// Shared constants, codes and command/status types of the two-point ADC correction block.
`default_nettype none

package adc2p_pkg;

  localparam int MaxAverage   = 256;
  localparam int GainFracBits = 16;

  localparam int SampleW   = 16;
  localparam int CntW      = 9;
  localparam int AdcBitsW  = 5;
  localparam int RefSumW   = 24;
  localparam int GainW     = 24;
  localparam int ProdW     = GainW + SampleW;
  localparam int SumW      = 50;
  localparam int MeanW     = 17;
  localparam int DivW      = 33;
  localparam int DvsW      = 16;
  localparam int DivCntW   = $clog2(DivW + 1);
  localparam int KindW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 16;
  localparam int OutFieldW = MeanW + 2 * SampleW + GainW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW   = OutDataW - OutFieldW;

  localparam int MinAdcBits = 8;
  localparam int MaxAdcBits = 16;

  localparam logic [GainW-1:0]    GainMax       = '1;
  localparam logic [GainW-1:0]    GainUnity     = GainW'(1 << GainFracBits);
  localparam logic [CntW-1:0]     AvgCountReset = CntW'(1);
  localparam logic [AdcBitsW-1:0] AdcBitsReset  = AdcBitsW'(12);
  localparam logic [MeanW-1:0]    MeanMax       = {1'b0, {(MeanW - 1){1'b1}}};
  localparam logic [MeanW-1:0]    MeanMin       = {1'b1, {(MeanW - 1){1'b0}}};
  localparam logic [DivW-1:0]     MeanMaxMag    = DivW'(65535);
  localparam logic [DivW-1:0]     MeanMinMag    = DivW'(65536);

  typedef enum logic [1:0] {
    ReqGround  = 2'd0,
    ReqSupply  = 2'd1,
    ReqMeasure = 2'd2,
    ReqNone    = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    KindMean   = 2'd0,
    KindGround = 2'd1,
    KindSupply = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAvgCount     = 2'd0,
    CfgAdcBits      = 2'd1,
    CfgPresetGround = 2'd2,
    CfgPresetSupply = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    SrcGround = 2'd0,
    SrcSupply = 2'd1,
    SrcGain   = 2'd2,
    SrcMean   = 2'd3
  } src_e;

  typedef struct packed {
    logic  accept;
    logic  mul_item;
    logic  mul_ground;
    logic  acc;
    logic  round;
    logic  div_start;
    logic  commit;
    logic  gain_unity;
    logic  off_load;
    logic  emit;
    src_e  div_src;
    kind_e emit_kind;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic run_end;
    logic div_done;
    logic degenerate;
    logic out_free;
    logic preset_wr;
  } stat_t;

endpackage

`default_nettype wire

### hdl/adc2p_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module adc2p_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [adc2p_pkg::DivW-1:0]    dividend_i,
  input  wire logic [adc2p_pkg::DvsW-1:0]    divisor_i,
  output logic                               done_o,
  output logic [adc2p_pkg::DivW-1:0]         quotient_o
);

  logic [adc2p_pkg::DivW-1:0]    quo_q;
  logic [adc2p_pkg::DvsW-1:0]    rem_q;
  logic [adc2p_pkg::DvsW-1:0]    dvs_q;
  logic [adc2p_pkg::DivCntW-1:0] cnt_q;
  logic                          run_q;
  logic                          done_q;
  logic [adc2p_pkg::DvsW:0]      rem_sh;
  logic [adc2p_pkg::DvsW:0]      diff;
  logic                          ge;

  assign rem_sh = {rem_q, quo_q[adc2p_pkg::DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= adc2p_pkg::DivCntW'(adc2p_pkg::DivW);
    end else if (run_q) begin
      cnt_q  <= cnt_q - adc2p_pkg::DivCntW'(1);
      run_q  <= cnt_q != adc2p_pkg::DivCntW'(1);
      done_q <= cnt_q == adc2p_pkg::DivCntW'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[adc2p_pkg::DivW-2:0], ge};
      rem_q <= ge ? diff[adc2p_pkg::DvsW-1:0] : rem_sh[adc2p_pkg::DvsW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### hdl/adc2p_dp.sv
// Datapath: configuration, levels, gain, accumulators, multiplier, divider and result register.
`default_nettype none

module adc2p_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire adc2p_pkg::cmd_t                  cmd_i,
  output adc2p_pkg::stat_t                      stat_o,
  input  wire logic [adc2p_pkg::InDataW-1:0]    s_tdata_i,
  input  wire logic [1:0]                       s_tuser_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [adc2p_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [adc2p_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                             m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [adc2p_pkg::OutDataW-1:0]        m_tdata_o,
  output logic [adc2p_pkg::KindW-1:0]           m_tuser_o
);

  logic [adc2p_pkg::CntW-1:0]     avg_count_q;
  logic [adc2p_pkg::AdcBitsW-1:0] adc_bits_q;
  logic [adc2p_pkg::SampleW-1:0]  ground_q;
  logic [adc2p_pkg::SampleW-1:0]  supply_q;
  logic [adc2p_pkg::GainW-1:0]    gain_q;
  logic [adc2p_pkg::ProdW-1:0]    offset_q;
  logic [adc2p_pkg::SumW-1:0]     msum_q;
  logic [adc2p_pkg::CntW-1:0]     mcnt_q;
  logic [adc2p_pkg::RefSumW-1:0]  gsum_q;
  logic [adc2p_pkg::CntW-1:0]     gcnt_q;
  logic [adc2p_pkg::RefSumW-1:0]  ssum_q;
  logic [adc2p_pkg::CntW-1:0]     scnt_q;
  logic [adc2p_pkg::MeanW-1:0]    mean_q;
  logic                           neg_q;
  adc2p_pkg::req_e                req_q;
  logic [adc2p_pkg::SampleW-1:0]  sample_q;
  logic [adc2p_pkg::ProdW-1:0]    prod_q;
  logic                           out_valid_q;
  adc2p_pkg::kind_e               out_kind_q;
  logic [adc2p_pkg::MeanW-1:0]    out_mean_q;
  logic [adc2p_pkg::SampleW-1:0]  out_ground_q;
  logic [adc2p_pkg::SampleW-1:0]  out_supply_q;
  logic [adc2p_pkg::GainW-1:0]    out_gain_q;

  logic [adc2p_pkg::CntW-1:0]     run_len;
  logic [adc2p_pkg::RefSumW-1:0]  gsum_new;
  logic [adc2p_pkg::RefSumW-1:0]  ssum_new;
  logic [adc2p_pkg::CntW-1:0]     gcnt_new;
  logic [adc2p_pkg::CntW-1:0]     scnt_new;
  logic [adc2p_pkg::CntW-1:0]     mcnt_new;
  logic [adc2p_pkg::SumW-1:0]     msum_new;
  logic                           run_end;
  logic [adc2p_pkg::AdcBitsW-1:0] bits;
  logic [adc2p_pkg::SampleW:0]    one_sh;
  logic [adc2p_pkg::SampleW-1:0]  full_scale;
  logic [adc2p_pkg::SumW-1:0]     mean_num;
  logic [adc2p_pkg::DivW-1:0]     dvd;
  logic [adc2p_pkg::DvsW-1:0]     dvs;
  logic                           div_done;
  logic [adc2p_pkg::DivW-1:0]     div_q;
  logic [adc2p_pkg::GainW-1:0]    gain_sat;
  logic [adc2p_pkg::MeanW-1:0]    mean_sat;
  logic [adc2p_pkg::SampleW-1:0]  mul_b;
  logic                           preset_ground_wr;
  logic                           preset_supply_wr;
  logic                           out_free;

  always_comb begin
    if (avg_count_q == '0) begin
      run_len = adc2p_pkg::CntW'(1);
    end else if (avg_count_q > adc2p_pkg::CntW'(adc2p_pkg::MaxAverage)) begin
      run_len = adc2p_pkg::CntW'(adc2p_pkg::MaxAverage);
    end else begin
      run_len = avg_count_q;
    end
  end

  assign gsum_new = gsum_q + adc2p_pkg::RefSumW'(sample_q);
  assign ssum_new = ssum_q + adc2p_pkg::RefSumW'(sample_q);
  assign gcnt_new = gcnt_q + adc2p_pkg::CntW'(1);
  assign scnt_new = scnt_q + adc2p_pkg::CntW'(1);
  assign mcnt_new = mcnt_q + adc2p_pkg::CntW'(1);
  assign msum_new = msum_q + adc2p_pkg::SumW'(prod_q) - adc2p_pkg::SumW'(offset_q);

  always_comb begin
    case (req_q)
      adc2p_pkg::ReqGround:  run_end = gcnt_new >= run_len;
      adc2p_pkg::ReqSupply:  run_end = scnt_new >= run_len;
      adc2p_pkg::ReqMeasure: run_end = mcnt_new >= run_len;
      default:               run_end = 1'b0;
    endcase
  end

  always_comb begin
    if (adc_bits_q < adc2p_pkg::AdcBitsW'(adc2p_pkg::MinAdcBits)) begin
      bits = adc2p_pkg::AdcBitsW'(adc2p_pkg::MinAdcBits);
    end else if (adc_bits_q > adc2p_pkg::AdcBitsW'(adc2p_pkg::MaxAdcBits)) begin
      bits = adc2p_pkg::AdcBitsW'(adc2p_pkg::MaxAdcBits);
    end else begin
      bits = adc_bits_q;
    end
  end

  assign one_sh     = (adc2p_pkg::SampleW + 1)'(1) << bits;
  assign full_scale = adc2p_pkg::SampleW'(one_sh - (adc2p_pkg::SampleW + 1)'(1));

  // Magnitude plus half the divisor, all in one add; the low fraction bits drop below.
  assign mean_num = (msum_q[adc2p_pkg::SumW-1] ? ~msum_q : msum_q)
                  + adc2p_pkg::SumW'({mcnt_q, {(adc2p_pkg::GainFracBits - 1){1'b0}}})
                  + adc2p_pkg::SumW'(msum_q[adc2p_pkg::SumW-1]);

  always_comb begin
    case (cmd_i.div_src)
      adc2p_pkg::SrcGround: begin
        dvd = adc2p_pkg::DivW'(gsum_new);
        dvs = adc2p_pkg::DvsW'(gcnt_new);
      end
      adc2p_pkg::SrcSupply: begin
        dvd = adc2p_pkg::DivW'(ssum_new);
        dvs = adc2p_pkg::DvsW'(scnt_new);
      end
      adc2p_pkg::SrcGain: begin
        dvd = adc2p_pkg::DivW'({full_scale, {adc2p_pkg::GainFracBits{1'b0}}});
        dvs = supply_q - ground_q;
      end
      default: begin
        dvd = mean_num[adc2p_pkg::GainFracBits +: adc2p_pkg::DivW];
        dvs = adc2p_pkg::DvsW'(mcnt_q);
      end
    endcase
  end

  adc2p_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign gain_sat = (div_q > adc2p_pkg::DivW'(adc2p_pkg::GainMax)) ? adc2p_pkg::GainMax
                                                                  : div_q[adc2p_pkg::GainW-1:0];

  always_comb begin
    if (neg_q) begin
      mean_sat = (div_q > adc2p_pkg::MeanMinMag) ? adc2p_pkg::MeanMin
                                                 : -div_q[adc2p_pkg::MeanW-1:0];
    end else begin
      mean_sat = (div_q > adc2p_pkg::MeanMaxMag) ? adc2p_pkg::MeanMax
                                                 : div_q[adc2p_pkg::MeanW-1:0];
    end
  end

  assign mul_b = cmd_i.mul_ground ? ground_q : sample_q;

  assign preset_ground_wr = cfg_we_i && (cfg_idx_i == adc2p_pkg::CfgPresetGround);
  assign preset_supply_wr = cfg_we_i && (cfg_idx_i == adc2p_pkg::CfgPresetSupply);
  assign out_free         = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_count_q <= adc2p_pkg::AvgCountReset;
      adc_bits_q  <= adc2p_pkg::AdcBitsReset;
      ground_q    <= '0;
      supply_q    <= '0;
      gain_q      <= adc2p_pkg::GainUnity;
      offset_q    <= '0;
      msum_q      <= '0;
      mcnt_q      <= '0;
      gsum_q      <= '0;
      gcnt_q      <= '0;
      ssum_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == adc2p_pkg::CfgAvgCount)) begin
        avg_count_q <= cfg_data_i[adc2p_pkg::CntW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == adc2p_pkg::CfgAdcBits)) begin
        adc_bits_q <= cfg_data_i[adc2p_pkg::AdcBitsW-1:0];
      end
      if (preset_ground_wr) begin
        ground_q <= cfg_data_i;
      end
      if (preset_supply_wr) begin
        supply_q <= cfg_data_i;
      end

      if (cmd_i.acc) begin
        case (req_q)
          adc2p_pkg::ReqGround: begin
            gsum_q <= run_end ? '0 : gsum_new;
            gcnt_q <= run_end ? '0 : gcnt_new;
          end
          adc2p_pkg::ReqSupply: begin
            ssum_q <= run_end ? '0 : ssum_new;
            scnt_q <= run_end ? '0 : scnt_new;
          end
          adc2p_pkg::ReqMeasure: begin
            msum_q <= msum_new;
            mcnt_q <= mcnt_new;
          end
          default: ;
        endcase
      end

      if (cmd_i.round) begin
        msum_q <= '0;
        mcnt_q <= '0;
      end

      if (div_done && cmd_i.commit) begin
        case (cmd_i.div_src)
          adc2p_pkg::SrcGround: ground_q <= div_q[adc2p_pkg::SampleW-1:0];
          adc2p_pkg::SrcSupply: supply_q <= div_q[adc2p_pkg::SampleW-1:0];
          adc2p_pkg::SrcGain:   gain_q   <= gain_sat;
          default: ;
        endcase
      end

      if (cmd_i.gain_unity) begin
        gain_q <= adc2p_pkg::GainUnity;
      end
      if (cmd_i.off_load) begin
        offset_q <= prod_q;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q    <= adc2p_pkg::req_e'(s_tuser_i);
      sample_q <= s_tdata_i[adc2p_pkg::SampleW-1:0];
    end
    if (cmd_i.mul_item || cmd_i.mul_ground) begin
      prod_q <= adc2p_pkg::ProdW'(gain_q) * adc2p_pkg::ProdW'(mul_b);
    end
    if (cmd_i.round) begin
      neg_q <= msum_q[adc2p_pkg::SumW-1];
    end
    if (div_done && cmd_i.commit && (cmd_i.div_src == adc2p_pkg::SrcMean)) begin
      mean_q <= mean_sat;
    end
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_mean_q   <= (cmd_i.emit_kind == adc2p_pkg::KindMean) ? mean_q : '0;
      out_ground_q <= ground_q;
      out_supply_q <= supply_q;
      out_gain_q   <= gain_q;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.req        = req_q;
    stat_o.run_end    = run_end;
    stat_o.div_done   = div_done;
    stat_o.degenerate = (supply_q == '0) || (supply_q <= ground_q);
    stat_o.out_free   = out_free;
    stat_o.preset_wr  = preset_ground_wr || preset_supply_wr;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tdata_o  = {{adc2p_pkg::OutPadW{1'b0}}, out_gain_q, out_supply_q, out_ground_q,
                       out_mean_q};

endmodule

`default_nettype wire

### hdl/adc2p_ctrl.sv
// Controller state machine sequencing accumulation, division, recompute and result transfer.
`default_nettype none

module adc2p_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic             cfg_we_i,
  input  wire adc2p_pkg::stat_t stat_i,
  output logic                  s_tready_o,
  output adc2p_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ROUND,
    S_DIV,
    S_GAIN,
    S_OFF,
    S_OFFW,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  adc2p_pkg::src_e  src_q, src_d;
  logic             emit_sup_q, emit_sup_d;

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_src   = src_q;
    cmd_o.emit_kind = adc2p_pkg::KindMean;
    state_d         = state_q;
    src_d           = src_q;
    emit_sup_d      = emit_sup_q;
    s_tready_o      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_tready_o   = !cfg_we_i;
        cmd_o.accept = s_tvalid_i && !cfg_we_i;
        if (cmd_o.accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_item = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_IDLE;
        if (stat_i.run_end) begin
          unique case (stat_i.req)
            adc2p_pkg::ReqGround: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_src   = adc2p_pkg::SrcGround;
              src_d           = adc2p_pkg::SrcGround;
              state_d         = S_DIV;
            end
            adc2p_pkg::ReqSupply: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_src   = adc2p_pkg::SrcSupply;
              src_d           = adc2p_pkg::SrcSupply;
              state_d         = S_DIV;
            end
            adc2p_pkg::ReqMeasure: begin
              state_d = S_ROUND;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ROUND: begin
        cmd_o.round     = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = adc2p_pkg::SrcMean;
        src_d           = adc2p_pkg::SrcMean;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.commit = 1'b1;
          unique case (src_q)
            adc2p_pkg::SrcSupply: begin
              emit_sup_d = 1'b1;
              state_d    = S_GAIN;
            end
            adc2p_pkg::SrcGain: begin
              state_d = S_OFF;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_GAIN: begin
        if (stat_i.degenerate) begin
          cmd_o.gain_unity = 1'b1;
          state_d          = S_OFF;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = adc2p_pkg::SrcGain;
          src_d           = adc2p_pkg::SrcGain;
          state_d         = S_DIV;
        end
      end
      S_OFF: begin
        cmd_o.mul_ground = 1'b1;
        state_d          = S_OFFW;
      end
      S_OFFW: begin
        cmd_o.off_load = 1'b1;
        state_d        = emit_sup_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        unique case (src_q)
          adc2p_pkg::SrcGround: cmd_o.emit_kind = adc2p_pkg::KindGround;
          adc2p_pkg::SrcMean:   cmd_o.emit_kind = adc2p_pkg::KindMean;
          default:              cmd_o.emit_kind = adc2p_pkg::KindSupply;
        endcase
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // restart the gain and offset recompute on a preset level write
    if (stat_i.preset_wr) begin
      state_d    = S_GAIN;
      emit_sup_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      src_q      <= adc2p_pkg::SrcGround;
      emit_sup_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      src_q      <= src_d;
      emit_sup_q <= emit_sup_d;
    end
  end

endmodule

`default_nettype wire

### hdl/adc_two_point_correction_averager.sv
// Top level of the two-point ADC gain/offset correction and averaging block.
//
// Input stream: tuser carries the sample kind (ground reference, supply
// reference, measurement), tdata the raw 16-bit reading. Output stream: tuser
// carries the result kind, tdata the corrected mean, both levels and the gain.
// The config port writes run length, resolution and the two preset levels.
//
// One item at a time: a new sample is taken only when the last is through. A
// run end goes through the shared 33-step serial divider: one division for a
// ground or measurement run end, and for a supply run end the level division,
// then the gain division and the offset multiply, where the gain division is
// skipped when the supply level gives unity gain. A preset level write restarts
// the gain/offset recompute with tready low.
// Reset loads unity gain, zero levels and empty runs. A result waits in the
// output register while tready is low; the next sample is still taken and
// the block stalls only when it has another result to hand over.
`default_nettype none

module adc_two_point_correction_averager (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [adc2p_pkg::InDataW-1:0]    s_axis_tdata,  // [15:0] sample
  input  wire logic [1:0]                       s_axis_tuser,  // [1:0] req_type
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [16:0] corrected_mean, [32:17] ground_level, [48:33] supply_level, [72:49] gain_out
  output logic [adc2p_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic [adc2p_pkg::KindW-1:0]           m_axis_tuser,  // [1:0] result_kind
  input  wire logic                             cfg_we_i,
  input  wire logic [adc2p_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [adc2p_pkg::CfgDataW-1:0]   cfg_data_i
);

  adc2p_pkg::cmd_t  cmd;
  adc2p_pkg::stat_t stat;

  adc2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .cfg_we_i   (cfg_we_i),
    .stat_i     (stat),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  adc2p_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### hdl/adc2p_chk.sv
// Port-level assertion checker for the correction block, bound to the top level.
`default_nettype none

module adc2p_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [adc2p_pkg::OutDataW-1:0]   m_axis_tdata,
  input wire logic [adc2p_pkg::KindW-1:0]      m_axis_tuser,
  input wire logic                             cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while the first is in work");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !s_axis_tready)
    else $error("sample transfer offered during a config write");

  a_cal_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != adc2p_pkg::KindW'(adc2p_pkg::KindMean))
      |-> m_axis_tdata[adc2p_pkg::MeanW-1:0] == '0)
    else $error("calibration result carries a nonzero mean");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

endmodule

bind adc_two_point_correction_averager adc2p_chk u_adc2p_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the two-point ADC correction and averaging block.
`timescale 1ns / 1ps

module testbench;
  import adc2p_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int SettleTicks = 100;

  typedef struct {
    req_e              req;
    logic [SampleW-1:0] value;
  } adc_sample_t;

  typedef struct {
    kind_e              kind;
    logic [MeanW-1:0]   mean;
    logic [SampleW-1:0] ground;
    logic [SampleW-1:0] supply;
    logic [GainW-1:0]   gain;
  } cal_result_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  adc_sample_t adc_sample_q[$];
  cal_result_t mean_and_cal_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  logic [CntW-1:0]     avg_cnt = AvgCountReset;
  logic [AdcBitsW-1:0] res_bits = AdcBitsReset;
  logic [SampleW-1:0]  gnd_lvl = '0;
  logic [SampleW-1:0]  sup_lvl = '0;
  logic [GainW-1:0]    gain_q = GainUnity;
  longint              offset_q = 0;
  longint              meas_sum = 0;
  int unsigned         meas_cnt = 0;
  int unsigned         gnd_acc = 0;
  int unsigned         gnd_cnt = 0;
  int unsigned         sup_acc = 0;
  int unsigned         sup_cnt = 0;

  logic [15:0] phase_avg [12] = '{16'hFFFF, 4, 3, 1, 2, 8, 5, 16, 7, 256, 3, 1};
  int unsigned phase_len [12] = '{40, 70, 70, 70, 70, 70, 70, 70, 70, 260, 70, 70};

  adc_two_point_correction_averager u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned run_len();
    int unsigned n;
    n = avg_cnt;
    if (n == 0) n = 1;
    if (n > MaxAverage) n = MaxAverage;
    return n;
  endfunction

  task automatic update_gain();
    int unsigned bits;
    bit [63:0]   full_scale;
    bit [63:0]   g;
    bit [63:0]   prod;
    bits = res_bits;
    if (bits < MinAdcBits) bits = MinAdcBits;
    if (bits > MaxAdcBits) bits = MaxAdcBits;
    full_scale = (64'd1 << bits) - 64'd1;
    if (sup_lvl == 0 || sup_lvl <= gnd_lvl) begin
      gain_q = GainUnity;
    end else begin
      g = (full_scale << GainFracBits) / ({48'd0, sup_lvl} - {48'd0, gnd_lvl});
      gain_q = (g > 64'(GainMax)) ? GainMax : g[GainW-1:0];
    end
    prod = {40'd0, gain_q} * {48'd0, gnd_lvl};
    offset_q = -longint'(prod);
  endtask

  task automatic push_result(kind_e kind, logic [MeanW-1:0] mean);
    cal_result_t r;
    r.kind = kind;
    r.mean = mean;
    r.ground = gnd_lvl;
    r.supply = sup_lvl;
    r.gain = gain_q;
    mean_and_cal_q.push_back(r);
  endtask

  task automatic correct_sample(req_e req, logic [SampleW-1:0] s);
    int unsigned      n;
    bit [63:0]        d;
    bit [63:0]        mag;
    bit [63:0]        q;
    bit [63:0]        neg_q;
    bit               neg;
    logic [MeanW-1:0] mean;
    n = run_len();
    case (req)
      ReqGround: begin
        gnd_acc += s;
        gnd_cnt++;
        if (gnd_cnt >= n) begin
          gnd_lvl = SampleW'(gnd_acc / gnd_cnt);
          gnd_acc = 0;
          gnd_cnt = 0;
          push_result(KindGround, '0);
        end
      end
      ReqSupply: begin
        sup_acc += s;
        sup_cnt++;
        if (sup_cnt >= n) begin
          sup_lvl = SampleW'(sup_acc / sup_cnt);
          sup_acc = 0;
          sup_cnt = 0;
          update_gain();
          push_result(KindSupply, '0);
        end
      end
      ReqMeasure: begin
        meas_sum += longint'({40'd0, gain_q} * {48'd0, s}) + offset_q;
        meas_cnt++;
        if (meas_cnt >= n) begin
          d = 64'(meas_cnt) << GainFracBits;
          neg = meas_sum < 0;
          mag = neg ? -meas_sum : meas_sum;
          q = (mag + d / 2) / d;
          neg_q = 64'd0 - q;
          if (neg) mean = (q > 64'd65536) ? MeanMin : neg_q[MeanW-1:0];
          else mean = (q > 64'd65535) ? MeanMax : q[MeanW-1:0];
          meas_sum = 0;
          meas_cnt = 0;
          push_result(KindMean, mean);
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        correct_sample(req_e'(s_axis_tuser), s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (adc_sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= adc_sample_q[0].req;
          s_axis_tdata <= adc_sample_q[0].value;
          void'(adc_sample_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [GainW-1:0] exp_v,
                                      logic [GainW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // monitor
  always @(posedge clk_i) begin
    cal_result_t r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (mean_and_cal_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual kind %0d data %h",
                   $realtime, m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          r = mean_and_cal_q.pop_front();
          check_field("result_kind", GainW'(r.kind), GainW'(m_axis_tuser));
          check_field("corrected_mean", GainW'(r.mean), GainW'(m_axis_tdata[16:0]));
          check_field("ground_level", GainW'(r.ground), GainW'(m_axis_tdata[32:17]));
          check_field("supply_level", GainW'(r.supply), GainW'(m_axis_tdata[48:33]));
          check_field("gain_out", r.gain, m_axis_tdata[72:49]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("adc_two_point_correction_averager regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_sample(req_e req, logic [SampleW-1:0] value);
    adc_sample_t it;
    it.req = req;
    it.value = value;
    adc_sample_q.push_back(it);
  endtask

  task automatic drain();
    while (adc_sample_q.size() != 0 || s_axis_tvalid || mean_and_cal_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAvgCount: avg_cnt = value[CntW-1:0];
      CfgAdcBits: res_bits = value[AdcBitsW-1:0];
      CfgPresetGround: begin
        gnd_lvl = value;
        update_gain();
      end
      default: begin
        sup_lvl = value;
        update_gain();
      end
    endcase
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(req_e req);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return SampleW'($urandom);
      default: begin
        if (req == ReqGround) return SampleW'($urandom_range(2000));
        if (req == ReqSupply) return SampleW'($urandom_range(65535, 3000));
        return SampleW'($urandom);
      end
    endcase
  endfunction

  task automatic random_phase(int unsigned n_items);
    int unsigned taken;
    int unsigned len;
    int unsigned pick;
    req_e        req;
    taken = 0;
    while (taken < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        queue_sample(ReqNone, SampleW'($urandom));
      end else begin
        if (pick < 25) req = ReqGround;
        else if (pick < 45) req = ReqSupply;
        else req = ReqMeasure;
        len = run_len();
        if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
        repeat (len) queue_sample(req, pick_sample(req));
        taken += len;
      end
    end
  endtask

  task automatic set_idling(int unsigned mode);
    send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 82 : 0;
    recv_idle_pct = (mode == 0) ? 82 : (mode == 1) ? 13 : 0;
  endtask

  initial begin
    set_idling(0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unity gain, then real and degenerate calibrations
    queue_sample(ReqMeasure, 16'h0000);
    queue_sample(ReqMeasure, 16'hFFFF);
    queue_sample(ReqNone, 16'hFFFF);
    queue_sample(ReqGround, 16'h0000);
    queue_sample(ReqSupply, 16'hFFFF);
    queue_sample(ReqMeasure, 16'h5555);
    queue_sample(ReqMeasure, 16'hAAAA);
    queue_sample(ReqGround, 16'hFFFF);
    queue_sample(ReqMeasure, 16'h0000);
    queue_sample(ReqSupply, 16'h0000);
    queue_sample(ReqMeasure, 16'h0000);
    queue_sample(ReqMeasure, 16'hFFFF);
    queue_sample(ReqSupply, 16'd100);
    drain();

    // saturated gain and saturated means
    write_reg(CfgAdcBits, 16'd16);
    write_reg(CfgPresetGround, 16'd1000);
    write_reg(CfgPresetSupply, 16'd1001);
    queue_sample(ReqMeasure, 16'h0000);
    queue_sample(ReqMeasure, 16'hFFFF);
    queue_sample(ReqGround, 16'd2000);
    queue_sample(ReqMeasure, 16'd1500);
    drain();

    write_reg(CfgAvgCount, 16'd0);
    queue_sample(ReqMeasure, 16'd7);
    queue_sample(ReqSupply, 16'd0);

    for (int p = 0; p < 12; p++) begin
      drain();
      set_idling(p * 3 / 12);
      write_reg(CfgAvgCount, phase_avg[p]);
      write_reg(CfgAdcBits, CfgDataW'($urandom));
      if ($urandom_range(2) == 0) begin
        write_reg(CfgPresetGround, CfgDataW'($urandom_range(4000)));
      end
      if ($urandom_range(2) == 0) begin
        write_reg(CfgPresetSupply, ($urandom_range(3) == 0) ? '0 : CfgDataW'($urandom));
      end
      random_phase(phase_len[p]);
    end
    drain();

    if (mismatch_count == 0 && mean_and_cal_q.size() == 0) begin
      $display("adc_two_point_correction_averager regression: pass");
    end else begin
      $display("adc_two_point_correction_averager regression: fail");
    end
    $finish;
  end

endmodule

### adc_two_point_correction_averager.f
hdl/adc2p_pkg.sv
hdl/adc2p_div.sv
hdl/adc2p_dp.sv
hdl/adc2p_ctrl.sv
hdl/adc_two_point_correction_averager.sv
hdl/adc2p_chk.sv
test/testbench.sv
